@@ rtl/utf16_to_utf8_encoder_macros.svh @@
// Assertion macros shared by the UTF-16 to UTF-8 encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef UTF16_TO_UTF8_ENCODER_MACROS_SVH
`define UTF16_TO_UTF8_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U16U8_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/u16u8_pkg.sv @@
// Package for the UTF-16 to UTF-8 encoder: item types, code point jobs,
// UTF-8 length and byte helpers. No dependencies.
package u16u8_pkg;

    // Surrogate prefixes (upper six bits of a code unit)
    localparam logic [5:0] HI_PREFIX = 6'b110110;
    localparam logic [5:0] LO_PREFIX = 6'b110111;

    // UTF-8 length codes (byte count minus one)
    localparam logic [1:0] LEN_1B = 2'd0;
    localparam logic [1:0] LEN_2B = 2'd1;
    localparam logic [1:0] LEN_3B = 2'd2;
    localparam logic [1:0] LEN_4B = 2'd3;

    // Lead and continuation marks
    localparam logic [7:0] LEAD_2B   = 8'hC0;
    localparam logic [7:0] LEAD_3B   = 8'hE0;
    localparam logic [7:0] LEAD_4B   = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam int          QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        stream_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // One code point to encode
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  len_m1;
        logic        last;
    } cp_job_t;

    // Byte count minus one for a code point
    function automatic logic [1:0] cp_len_m1(input logic [20:0] cp);
        logic [1:0] len;
        if (cp < 21'h80) begin
            len = LEN_1B;
        end else if (cp < 21'h800) begin
            len = LEN_2B;
        end else if (cp < 21'h10000) begin
            len = LEN_3B;
        end else begin
            len = LEN_4B;
        end
        return len;
    endfunction

    // UTF-8 byte at position idx (0 = lead) of a code point
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [1:0]  len_m1,
                                             input logic [1:0]  idx);
        logic [7:0] b;
        logic [1:0] k;
        logic [5:0] chunk;
        k = len_m1 - idx;
        case (k)
            2'd0:    chunk = cp[5:0];
            2'd1:    chunk = cp[11:6];
            2'd2:    chunk = cp[17:12];
            default: chunk = {3'b000, cp[20:18]};
        endcase
        if (idx == 2'd0) begin
            case (len_m1)
                LEN_1B:  b = {1'b0, cp[6:0]};
                LEN_2B:  b = LEAD_2B | {3'b000, cp[10:6]};
                LEN_3B:  b = LEAD_3B | {4'b0000, cp[15:12]};
                default: b = LEAD_4B | {5'b00000, cp[20:18]};
            endcase
        end else begin
            b = CONT_MARK | {2'b00, chunk};
        end
        return b;
    endfunction

endpackage

@@ rtl/u16u8_front.sv @@
// Front end of the UTF-16 to UTF-8 encoder: accepts code units, pairs
// surrogates and pushes code point jobs. Depends on u16u8_pkg.
`include "utf16_to_utf8_encoder_macros.svh"

module u16u8_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  u16u8_pkg::in_item_t s_item,
    input  logic                q_full,
    output logic                push,
    output u16u8_pkg::cp_job_t  push_job
);

    logic               pending_reg, pending_next;
    logic [9:0]         held_reg, held_next;
    logic               extra_reg, extra_next;
    u16u8_pkg::cp_job_t extra_job_reg, extra_job_next;

    logic               accept;
    logic               is_high, is_low, hold_new;
    u16u8_pkg::cp_job_t unit_job;

    // Classify the incoming unit
    assign is_high  = (s_item.code_unit[15:10] == u16u8_pkg::HI_PREFIX);
    assign is_low   = (s_item.code_unit[15:10] == u16u8_pkg::LO_PREFIX);
    assign hold_new = is_high && !s_item.stream_end;

    assign unit_job.cp     = {5'b00000, s_item.code_unit};
    assign unit_job.len_m1 = u16u8_pkg::cp_len_m1({5'b00000, s_item.code_unit});
    assign unit_job.last   = 1'b1;

    // Stall while a second job is still owed or the queue is full
    assign s_ready = !extra_reg && !q_full;
    assign accept  = s_valid && s_ready;

    // Pair surrogates and choose the job(s) for this item
    always_comb begin
        pending_next   = pending_reg;
        held_next      = held_reg;
        extra_next     = extra_reg;
        extra_job_next = extra_job_reg;
        push           = 1'b0;
        push_job       = unit_job;
        if (extra_reg) begin
            if (!q_full) begin
                push       = 1'b1;
                push_job   = extra_job_reg;
                extra_next = 1'b0;
            end
        end else if (accept) begin
            if (pending_reg) begin
                push = 1'b1;
                if (is_low) begin
                    push_job.cp     = {1'b0, held_reg, s_item.code_unit[9:0]}
                                      + u16u8_pkg::SUPP_BASE;
                    push_job.len_m1 = u16u8_pkg::LEN_4B;
                    push_job.last   = 1'b1;
                    pending_next    = 1'b0;
                end else begin
                    // Encode the lone held high surrogate first
                    push_job.cp     = {5'b00000, u16u8_pkg::HI_PREFIX, held_reg};
                    push_job.len_m1 = u16u8_pkg::LEN_3B;
                    push_job.last   = hold_new;
                    pending_next    = hold_new;
                    held_next       = s_item.code_unit[9:0];
                    if (!hold_new) begin
                        extra_next     = 1'b1;
                        extra_job_next = unit_job;
                    end
                end
            end else if (hold_new) begin
                pending_next = 1'b1;
                held_next    = s_item.code_unit[9:0];
            end else begin
                push = 1'b1;
            end
        end
    end

    // Update state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            held_reg    <= 10'd0;
            extra_reg   <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
            extra_reg   <= extra_next;
        end
    end

    // Hold the owed job payload
    always_ff @(posedge aclk) begin
        extra_job_reg <= extra_job_next;
    end

    `U16U8_ASSERT_NEXT(a_extra_blocks_input, aclk, aresetn,
        accept && pending_reg && !is_low && !hold_new, extra_reg && !s_ready,
        "front: owed job did not block input")

endmodule

@@ rtl/u16u8_queue.sv @@
// Two-entry job queue between the front and back of the encoder.
// Depends on u16u8_pkg.
`include "utf16_to_utf8_encoder_macros.svh"

module u16u8_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  u16u8_pkg::cp_job_t push_job,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output u16u8_pkg::cp_job_t head_job
);

    localparam int PTR_W = $clog2(u16u8_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(u16u8_pkg::QUEUE_DEPTH + 1);

    u16u8_pkg::cp_job_t entry_reg [u16u8_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(u16u8_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store pushed jobs
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    `U16U8_ASSERT_NOW(a_no_push_when_full, aclk, aresetn,
        push, !full, "queue: push while full")
    `U16U8_ASSERT_NOW(a_count_in_range, aclk, aresetn,
        1'b1, count_reg <= CNT_W'(u16u8_pkg::QUEUE_DEPTH), "queue: count overflow")

endmodule

@@ rtl/u16u8_back.sv @@
// Back end of the encoder: serializes each code point job into UTF-8
// bytes through an output register. Depends on u16u8_pkg.
`include "utf16_to_utf8_encoder_macros.svh"

module u16u8_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  u16u8_pkg::cp_job_t   head_job,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u16u8_pkg::out_item_t m_item
);

    logic                 busy_reg, busy_next;
    u16u8_pkg::cp_job_t   job_reg, job_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    u16u8_pkg::out_item_t m_item_reg, m_item_next;

    logic out_load, emit, finish;

    assign out_load = !m_valid_reg || m_ready;
    assign emit     = busy_reg && out_load;
    assign finish   = emit && (idx_reg == job_reg.len_m1);
    assign pop      = head_valid && (!busy_reg || finish);

    // Sequence bytes of the current job, take the next one on the last byte
    always_comb begin
        busy_next    = busy_reg;
        job_next     = job_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (out_load) begin
            m_valid_next = emit;
        end
        if (emit) begin
            m_item_next.out_byte = u16u8_pkg::utf8_byte(job_reg.cp, job_reg.len_m1, idx_reg);
            m_item_next.run_last = job_reg.last && (idx_reg == job_reg.len_m1);
            idx_next             = idx_reg + 1'b1;
        end
        if (pop) begin
            busy_next = 1'b1;
            job_next  = head_job;
            idx_next  = 2'd0;
        end else if (finish) begin
            busy_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `U16U8_ASSERT_NOW(a_idx_within_len, aclk, aresetn,
        busy_reg, idx_reg <= job_reg.len_m1, "back: byte index past length")

endmodule

@@ rtl/utf16_to_utf8_encoder.sv @@
// Channel   Prefix  Payload                         Handshake
// input     s_      code_unit[15:0], stream_end     s_valid / s_ready
// result    m_      out_byte[7:0], run_last         m_valid / m_ready
//
// The back end emits one UTF-8 byte per cycle while m_ready is high, so a
// code point gives one to four bytes; a unit that breaks a held surrogate
// adds three more. Units are accepted every cycle while the two-entry job
// queue has room. A unit that follows a held high surrogate and is not its
// low half makes two jobs and holds off input until the second is pushed.
// Reset (aresetn, synchronous, active low) drops any held surrogate and
// queued job. Results sit in an output register; m_ready low stalls bytes.
//
// Top level of the UTF-16 to UTF-8 encoder; ties front, queue and back.
// Depends on u16u8_pkg, u16u8_front, u16u8_queue and u16u8_back.
module utf16_to_utf8_encoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  u16u8_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output u16u8_pkg::out_item_t m_item
);

    logic               q_full, push, pop, head_valid;
    u16u8_pkg::cp_job_t push_job, head_job;

    u16u8_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    u16u8_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

@@ tb/sv/u16u8_sb_pkg.sv @@
// Scoreboard for the UTF-16 to UTF-8 encoder bench: tracks the held surrogate
// and queues the UTF-8 bytes due for each accepted code unit.
// Depends on u16u8_pkg for the item types and encoding constants.
package u16u8_sb_pkg;

    import u16u8_pkg::*;

    class utf8_scoreboard;
        logic       high_held;
        logic [9:0] held_bits;
        out_item_t  run_bytes[$];
        out_item_t  pending_bytes[$];
        int         errors;

        function new();
            high_held = 1'b0;
            held_bits = '0;
            errors    = 0;
        endfunction

        function void push_byte(input logic [7:0] b);
            out_item_t entry;
            entry.out_byte = b;
            entry.run_last = 1'b0;
            run_bytes.push_back(entry);
        endfunction

        // Append the UTF-8 bytes of one code point, lead byte first
        function void encode_point(input logic [20:0] cp);
            if (cp < 21'h80) begin
                push_byte({1'b0, cp[6:0]});
            end else if (cp < 21'h800) begin
                push_byte(LEAD_2B | {3'b000, cp[10:6]});
                push_byte(CONT_MARK | {2'b00, cp[5:0]});
            end else if (cp < 21'h10000) begin
                push_byte(LEAD_3B | {4'b0000, cp[15:12]});
                push_byte(CONT_MARK | {2'b00, cp[11:6]});
                push_byte(CONT_MARK | {2'b00, cp[5:0]});
            end else begin
                push_byte(LEAD_4B | {5'b00000, cp[20:18]});
                push_byte(CONT_MARK | {2'b00, cp[17:12]});
                push_byte(CONT_MARK | {2'b00, cp[11:6]});
                push_byte(CONT_MARK | {2'b00, cp[5:0]});
            end
        endfunction

        // Advance the surrogate state by one accepted unit and queue its bytes
        function void note_unit(input in_item_t item);
            logic [15:0] u;
            logic        is_high;
            logic        is_low;
            logic        paired;
            u       = item.code_unit;
            is_high = (u[15:10] == HI_PREFIX);
            is_low  = (u[15:10] == LO_PREFIX);
            paired  = 1'b0;
            run_bytes.delete();

            // Resolve a held high surrogate: join with a low half or emit alone
            if (high_held) begin
                high_held = 1'b0;
                if (is_low) begin
                    encode_point(SUPP_BASE + {1'b0, held_bits, u[9:0]});
                    paired = 1'b1;
                end else begin
                    encode_point({5'b00000, HI_PREFIX, held_bits});
                end
                held_bits = '0;
            end

            // Hold a new high surrogate unless the stream ends here
            if (!paired) begin
                if (is_high && !item.stream_end) begin
                    high_held = 1'b1;
                    held_bits = u[9:0];
                end else begin
                    encode_point({5'b00000, u});
                end
            end

            if (run_bytes.size() > 0) begin
                run_bytes[run_bytes.size() - 1].run_last = 1'b1;
            end
            foreach (run_bytes[i]) begin
                pending_bytes.push_back(run_bytes[i]);
            end
        endfunction

        // Compare one output byte against the oldest queued byte
        function void check_byte(input out_item_t got);
            out_item_t want;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %h/%b",
                         $time, got.out_byte, got.run_last);
                errors++;
            end else begin
                want = pending_bytes.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte mismatch, expected %h, actual %h",
                             $time, want.out_byte, got.out_byte);
                    errors++;
                end
                if (got.run_last !== want.run_last) begin
                    $display("%0t: run_last mismatch, expected %b, actual %b",
                             $time, want.run_last, got.run_last);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

@@ tb/sv/tb_utf16_to_utf8_encoder.sv @@
// Top-level bench for utf16_to_utf8_encoder: directed and random code units
// with bursty input and stalled output, checked byte by byte.
// Depends on u16u8_pkg and u16u8_sb_pkg.
module tb_utf16_to_utf8_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import u16u8_pkg::*;
    import u16u8_sb_pkg::*;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    utf8_scoreboard sb = new();
    in_item_t       stim_units[$];

    utf16_to_utf8_encoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        forever begin
            #4 aclk = ~aclk;
        end
    end

    // Watch both channels and feed the scoreboard
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_unit(s_item);
            end
            if (m_valid && m_ready) begin
                sb.check_byte(m_item);
            end
        end
    end

    // Stall the result channel: ready runs, stall runs and random stretches
    initial begin
        int mode;
        int len;
        forever begin
            mode = $urandom_range(0, 2);
            len  = (mode == 1) ? $urandom_range(1, 10) : $urandom_range(1, 30);
            repeat (len) begin
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'b0;
                    end
                    default: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                endcase
                @(posedge aclk);
            end
        end
    end

    task automatic add_unit(input logic [15:0] u, input logic e);
        in_item_t item;
        item.code_unit  = u;
        item.stream_end = e;
        stim_units.push_back(item);
    endtask

    // Hold one item on the input until it is accepted
    task automatic send_unit(input in_item_t item);
        s_valid <= 1'b1;
        s_item  <= item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    // Drive a range of the stimulus queue in bursts with random gaps
    task automatic feed_range(input int first, input int stop);
        int i;
        int burst;
        int gap;
        i = first;
        while (i < stop) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && i < stop) begin
                send_unit(stim_units[i]);
                i++;
                burst--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
    endtask

    // Let the monitor note the last accepted item, then wait for every byte
    task automatic drain_results();
        @(posedge aclk);
        while (sb.pending_bytes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Random units, mostly well-formed pairs and BMP points, some noise
    task automatic build_random(input int count);
        int  pick;
        logic e;
        while (stim_units.size() < count) begin
            pick = $urandom_range(0, 99);
            e    = ($urandom_range(0, 11) == 0);
            if (pick < 10) begin
                add_unit(16'($urandom_range(16'h0000, 16'h007F)), e);
            end else if (pick < 25) begin
                add_unit(16'($urandom_range(16'h0080, 16'h07FF)), e);
            end else if (pick < 45) begin
                if ($urandom_range(0, 1) == 0) begin
                    add_unit(16'($urandom_range(16'h0800, 16'hD7FF)), e);
                end else begin
                    add_unit(16'($urandom_range(16'hE000, 16'hFFFF)), e);
                end
            end else if (pick < 80) begin
                add_unit(16'($urandom_range(16'hD800, 16'hDBFF)),
                         ($urandom_range(0, 19) == 0));
                add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), e);
            end else if (pick < 90) begin
                add_unit(16'($urandom_range(16'hD800, 16'hDBFF)), e);
            end else if (pick < 95) begin
                add_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), e);
            end else begin
                add_unit(16'($urandom), e);
            end
        end
    endtask

    initial begin
        int split;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: length boundaries, lone halves, pairs, broken pairs
        add_unit(16'h0000, 1'b0);
        add_unit(16'h007F, 1'b0);
        add_unit(16'h0080, 1'b0);
        add_unit(16'h07FF, 1'b0);
        add_unit(16'h0800, 1'b0);
        add_unit(16'hD7FF, 1'b0);
        add_unit(16'hE000, 1'b0);
        add_unit(16'hFFFF, 1'b0);
        add_unit(16'hDC00, 1'b0);
        add_unit(16'hDFFF, 1'b0);
        add_unit(16'hD800, 1'b0);
        add_unit(16'hDC00, 1'b0);
        add_unit(16'hDBFF, 1'b0);
        add_unit(16'hDFFF, 1'b0);
        add_unit(16'hDAAA, 1'b0);
        add_unit(16'h0041, 1'b0);
        add_unit(16'hD955, 1'b0);
        add_unit(16'hDB12, 1'b0);
        add_unit(16'hFFFF, 1'b0);
        add_unit(16'hD800, 1'b0);
        add_unit(16'hDBFF, 1'b1);
        add_unit(16'hDBFF, 1'b1);
        add_unit(16'hD834, 1'b0);
        add_unit(16'hDD1E, 1'b1);
        add_unit(16'h0000, 1'b1);
        feed_range(0, stim_units.size());
        drain_results();

        // Random part, with a full drain partway through
        split = stim_units.size();
        build_random(split + 410);
        feed_range(split, split + 200);
        drain_results();
        feed_range(split + 200, stim_units.size());
        drain_results();
        repeat (20) @(posedge aclk);

        if (sb.errors == 0 && sb.pending_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder.sv
tb/sv/u16u8_sb_pkg.sv
tb/sv/tb_utf16_to_utf8_encoder.sv
